>>> hdl/psdd_pkg.sv
`timescale 1ns / 1ps

package psdd_pkg;

    localparam int SCR_LEN = 23;
    localparam int TOP_BIT = SCR_LEN - 1;
    // delay taps of the two generator polynomials, as register bit positions
    localparam int GPA_TAP_LEFT  = 4;
    localparam int GPA_TAP_RIGHT = 18;
    localparam int GPC_TAP_LEFT  = 17;
    localparam int GPC_TAP_RIGHT = 5;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] RUN_MAX  = 16'hFFFF;
    localparam logic [15:0] MU_BIAS  = 16'h0084;

    typedef enum logic [2:0] {
        REG_BITS_PER_SYMBOL  = 3'd0,
        REG_LAW_SELECT       = 3'd1,
        REG_POLARITY_MODE    = 3'd2,
        REG_SCR_MODE         = 3'd3,
        REG_BIT_ORDER        = 3'd4,
        REG_THRESHOLD_LOW    = 3'd5,
        REG_THRESHOLD_MID    = 3'd6,
        REG_THRESHOLD_HIGH   = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        DSC_GPA_LEFT  = 2'd0,
        DSC_GPA_RIGHT = 2'd1,
        DSC_GPC_LEFT  = 2'd2,
        DSC_GPC_RIGHT = 2'd3
    } dsc_mode_t;

    typedef struct packed {
        logic [1:0]  bits_per_symbol;
        logic        law_select;
        logic [1:0]  polarity_mode;
        dsc_mode_t   scr_mode;
        logic [5:0]  bit_order;
        logic [15:0] thr_low;
        logic [15:0] thr_mid;
        logic [15:0] thr_high;
    } cfg_t;

    // one symbol's worth of reordered raw bits waiting for the descrambler
    typedef struct packed {
        logic [2:0] bits;
        logic [1:0] count;
    } qent_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

>>> hdl/psdd_front.sv
`timescale 1ns / 1ps

module psdd_front
    import psdd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_codeword,
    input  qstat_t      q_stat,
    output logic        q_push,
    output qent_t       q_ent
);

    logic        prev_sign_reg, prev_sign_next;
    logic        prev_valid_reg, prev_valid_next;

    logic [7:0]  mu_u;
    logic [15:0] mu_t;
    logic [15:0] mu_mag;
    logic        mu_sign;
    logic [7:0]  a_a;
    logic [3:0]  a_shamt;
    logic [15:0] a_mag;
    logic [15:0] mag;
    logic        sign;
    logic [1:0]  label;
    logic [2:0]  rec;
    logic [2:0]  bits;
    logic [1:0]  pos;
    logic        differential;
    logic        msb;
    logic        accept;
    logic        active;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;
    assign active  = accept && (cfg.bits_per_symbol != 2'd0);
    assign differential = !cfg.polarity_mode[1];

    // mu-law expansion
    assign mu_u    = ~s_codeword;
    assign mu_t    = ({9'd0, mu_u[3:0], 3'd0} + MU_BIAS) << mu_u[6:4];
    assign mu_mag  = mu_t - MU_BIAS;
    assign mu_sign = mu_u[7] && (mu_mag != 16'd0);

    // A-law expansion, never zero
    assign a_a     = s_codeword ^ 8'h55;
    assign a_shamt = {1'b0, a_a[6:4]} + 4'd2;
    always_comb begin
        if (a_a[6:4] != 3'd0) begin
            a_mag = {10'd0, 1'b1, a_a[3:0], 1'b1} << a_shamt;
        end else begin
            a_mag = {8'd0, a_a[3:0], 1'b1, 3'd0};
        end
    end

    assign mag  = cfg.law_select ? a_mag : mu_mag;
    assign sign = cfg.law_select ? !a_a[7] : mu_sign;

    always_comb begin
        label = 2'd0;
        rec   = 3'd0;
        bits  = 3'd0;
        pos   = 2'd0;
        unique case (cfg.bits_per_symbol)
            2'd2: begin
                label = (mag < cfg.thr_low) ? 2'd0 : 2'd1;
                rec[1] = label[0];
            end
            2'd3: begin
                if (mag < cfg.thr_low) begin
                    label = 2'd0;
                end else if (mag < cfg.thr_mid) begin
                    label = 2'd1;
                end else if (mag < cfg.thr_high) begin
                    label = 2'd2;
                end else begin
                    label = 2'd3;
                end
                rec[1] = label[1];
                rec[2] = label[0];
            end
            default: begin
                label = 2'd0;
            end
        endcase
        rec[0] = msb;
        // positions at or beyond the symbol size read as zero
        for (int i = 0; i < 3; i++) begin
            pos = cfg.bit_order[2*i +: 2];
            if (pos < cfg.bits_per_symbol) begin
                bits[i] = rec[pos];
            end
        end
    end

    assign msb = (differential ? (sign ^ prev_sign_reg) : sign) ^ cfg.polarity_mode[0];

    always_comb begin
        prev_sign_next  = prev_sign_reg;
        prev_valid_next = prev_valid_reg;
        q_push          = 1'b0;
        if (active) begin
            prev_sign_next  = sign;
            prev_valid_next = 1'b1;
            // a differential symbol with no sign history only primes it
            q_push = prev_valid_reg || !differential;
        end
    end

    assign q_ent.bits  = bits;
    assign q_ent.count = cfg.bits_per_symbol;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_sign_reg  <= 1'b0;
            prev_valid_reg <= 1'b0;
        end else begin
            prev_sign_reg  <= prev_sign_next;
            prev_valid_reg <= prev_valid_next;
        end
    end

    a_push_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (q_ent.count != 2'd0))
        else $error("symbol queued with no bits");

    a_push_primed: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |=> prev_valid_reg)
        else $error("sign history not valid after a queued symbol");

endmodule

>>> hdl/psdd_queue.sv
`timescale 1ns / 1ps

module psdd_queue
    import psdd_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  qent_t  push_ent,
    input  logic   pop,
    output qent_t  head_ent,
    output qstat_t stat
);

    qent_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_ent   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_ent;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

>>> hdl/psdd_back.sv
`timescale 1ns / 1ps

module psdd_back
    import psdd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  qstat_t      q_stat,
    input  qent_t       q_ent,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_data_bit,
    output logic        m_symbol_end,
    output logic [15:0] m_ones_run,
    output logic [15:0] m_longest_ones_run
);

    logic [SCR_LEN-1:0] shift_reg, shift_next;
    logic [1:0]         idx_reg, idx_next;
    logic [15:0]        run_reg, run_next;
    logic [15:0]        longest_reg, longest_next;
    logic               valid_reg, valid_next;
    logic               bit_out_reg, last_out_reg;
    logic               fire;
    logic               raw;
    logic               dbit;
    logic               last;

    assign fire = !q_stat.empty && (!valid_reg || m_ready);
    assign raw  = q_ent.bits[idx_reg];
    assign last = ({1'b0, idx_reg} + 3'd1) == {1'b0, q_ent.count};
    assign q_pop = fire && last;

    // self-synchronising descrambler, one bit a cycle while the queue holds bits and the output is not stalled
    always_comb begin
        unique case (cfg.scr_mode)
            DSC_GPA_LEFT: begin
                dbit       = raw ^ shift_reg[TOP_BIT] ^ shift_reg[GPA_TAP_LEFT];
                shift_next = {shift_reg[SCR_LEN-2:0], raw};
            end
            DSC_GPA_RIGHT: begin
                dbit       = raw ^ shift_reg[0] ^ shift_reg[GPA_TAP_RIGHT];
                shift_next = {raw, shift_reg[SCR_LEN-1:1]};
            end
            DSC_GPC_LEFT: begin
                dbit       = raw ^ shift_reg[TOP_BIT] ^ shift_reg[GPC_TAP_LEFT];
                shift_next = {shift_reg[SCR_LEN-2:0], raw};
            end
            DSC_GPC_RIGHT: begin
                dbit       = raw ^ shift_reg[0] ^ shift_reg[GPC_TAP_RIGHT];
                shift_next = {raw, shift_reg[SCR_LEN-1:1]};
            end
        endcase
        if (!fire) begin
            shift_next = shift_reg;
        end
    end

    always_comb begin
        idx_next     = idx_reg;
        run_next     = run_reg;
        longest_next = longest_reg;
        valid_next   = valid_reg && !m_ready;
        if (fire) begin
            valid_next = 1'b1;
            idx_next   = last ? 2'd0 : idx_reg + 2'd1;
            if (dbit) begin
                if (run_reg != RUN_MAX) begin
                    run_next = run_reg + 16'd1;
                end
                if (run_next > longest_reg) begin
                    longest_next = run_next;
                end
            end else begin
                run_next = 16'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            bit_out_reg  <= dbit;
            last_out_reg <= last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg   <= '0;
            idx_reg     <= 2'd0;
            run_reg     <= 16'd0;
            longest_reg <= 16'd0;
            valid_reg   <= 1'b0;
        end else begin
            shift_reg   <= shift_next;
            idx_reg     <= idx_next;
            run_reg     <= run_next;
            longest_reg <= longest_next;
            valid_reg   <= valid_next;
        end
    end

    assign m_valid            = valid_reg;
    assign m_data_bit         = bit_out_reg;
    assign m_symbol_end       = last_out_reg;
    assign m_ones_run         = run_reg;
    assign m_longest_ones_run = longest_reg;

    a_run_le_longest: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_ones_run <= m_longest_ones_run))
        else $error("current run exceeds longest run");

    a_zero_clears_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data_bit) |-> (m_ones_run == 16'd0))
        else $error("zero bit left a nonzero run");

    a_idx_in_symbol: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_stat.empty |-> (idx_reg < q_ent.count))
        else $error("bit index beyond symbol");

endmodule

>>> hdl/pam_symbol_descrambling_demodulator.sv
`timescale 1ns / 1ps
// a symbol's bits_per_symbol bits (1 to 3) pass the queue, then the output register
// throughput: one codeword per cycle while s_ready is high, into a four-entry symbol
// queue; the descrambler drains one bit per cycle unless stalled by m_ready or an empty
// queue; differentially primed or zero-size symbols yield no bits
// reset: synchronous active-low aresetn clears the queue, sign history, descrambler,
// run counters and registers to 1, 0, 0, 0, 36, 0, 0, 0
module pam_symbol_descrambling_demodulator
    import psdd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_codeword,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_data_bit,
    output logic        m_symbol_end,
    output logic [15:0] m_ones_run,
    output logic [15:0] m_longest_ones_run
);

    cfg_t   cfg_reg, cfg_next;
    qstat_t q_stat;
    qent_t  push_ent, head_ent;
    logic   q_push, q_pop;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (reg_idx_t'(cfg_index))
                REG_BITS_PER_SYMBOL:  cfg_next.bits_per_symbol  = cfg_data[1:0];
                REG_LAW_SELECT:       cfg_next.law_select       = cfg_data[0];
                REG_POLARITY_MODE:    cfg_next.polarity_mode    = cfg_data[1:0];
                REG_SCR_MODE:         cfg_next.scr_mode         = dsc_mode_t'(cfg_data[1:0]);
                REG_BIT_ORDER:        cfg_next.bit_order        = cfg_data[5:0];
                REG_THRESHOLD_LOW:    cfg_next.thr_low          = cfg_data;
                REG_THRESHOLD_MID:    cfg_next.thr_mid          = cfg_data;
                REG_THRESHOLD_HIGH:   cfg_next.thr_high         = cfg_data;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bits_per_symbol  <= 2'd1;
            cfg_reg.law_select       <= 1'b0;
            cfg_reg.polarity_mode    <= 2'd0;
            cfg_reg.scr_mode         <= DSC_GPA_LEFT;
            cfg_reg.bit_order        <= 6'd36;
            cfg_reg.thr_low          <= 16'd0;
            cfg_reg.thr_mid          <= 16'd0;
            cfg_reg.thr_high         <= 16'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    psdd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_codeword (s_codeword),
        .q_stat     (q_stat),
        .q_push     (q_push),
        .q_ent      (push_ent)
    );

    psdd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_ent (push_ent),
        .pop      (q_pop),
        .head_ent (head_ent),
        .stat     (q_stat)
    );

    psdd_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg                (cfg_reg),
        .q_stat             (q_stat),
        .q_ent              (head_ent),
        .q_pop              (q_pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_data_bit         (m_data_bit),
        .m_symbol_end       (m_symbol_end),
        .m_ones_run         (m_ones_run),
        .m_longest_ones_run (m_longest_ones_run)
    );

endmodule
